// ----- sv/kcm_pkg.sv -----
// Shared types, constants and helpers for the canonical k-mer minimizer.
// No dependencies; imported by every module of the block.
package kcm_pkg;

    localparam int MAX_KMER_BASES_DEF = 32;
    localparam int KMER_W             = 64;
    localparam int CFG_W              = 6;
    localparam int CFG_IDX_W          = 2;
    localparam int IDX_W              = 5;

    localparam logic [KMER_W-1:0] NO_WINDOW_VALUE = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KMER_LENGTH   = 2'd0,
        REG_WINDOW_LENGTH = 2'd1
    } cfg_reg_t;

    // One candidate window as it travels through the min tree.
    typedef struct packed {
        logic              vld;
        logic [KMER_W-1:0] val;
        logic [IDX_W-1:0]  idx;
    } cand_t;

    // Reverse complement over all 32 bases of a word (pure wiring).
    function automatic logic [KMER_W-1:0] kcm_rc32(input logic [KMER_W-1:0] w);
        logic [KMER_W-1:0] r;
        r = '0;
        for (int b = 0; b < KMER_W / 2; b++) begin
            r[2*(KMER_W/2-1-b) +: 2] = 2'd3 - w[2*b +: 2];
        end
        return r;
    endfunction

    // lo holds the lower window indexes; hi wins ties.
    function automatic cand_t kcm_pick(input cand_t lo, input cand_t hi);
        cand_t res;
        if (hi.vld && (!lo.vld || (hi.val <= lo.val))) begin
            res = hi;
        end
        else begin
            res = lo;
        end
        return res;
    endfunction

endpackage

// ----- sv/kmer_canonical_minimizer.sv -----
// Canonical minimizer of a 2-bit-per-base k-mer, fully pipelined.
// Stages from input accept to out_valid: two alignment stages, one window
// stage, one stage per level of the min tree, one output shift stage.
// Throughput: one item per cycle; a stall holds an occupied stage only while
// the stage after it cannot move. Reset (rst_n low, async) empties the
// pipeline and loads kmer_length = 31, window_length = 15.
module kmer_canonical_minimizer #(
    parameter int MAX_KMER_BASES = kcm_pkg::MAX_KMER_BASES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kcm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [kcm_pkg::KMER_W-1:0]     packed_kmer,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kcm_pkg::KMER_W-1:0]     minimizer_value,
    output logic [kcm_pkg::IDX_W-1:0]      minimizer_index
);
    import kcm_pkg::*;

    localparam int LOG   = $clog2(MAX_KMER_BASES);
    localparam int LANES = 1 << LOG;
    localparam int OUT   = LOG + 3;
    localparam logic [CFG_W-1:0] K_MAX = CFG_W'(MAX_KMER_BASES);

    logic [CFG_W-1:0] kmer_length_reg;
    logic [CFG_W-1:0] window_length_reg;

    logic [OUT:0] vld_reg;
    logic [OUT:0] adv;

    // stage 0
    logic [KMER_W-1:0] fwd_reg,  fwd_next;
    logic [KMER_W-1:0] rev_reg,  rev_next;
    logic [KMER_W-1:0] mask_reg, mask_next;
    logic [CFG_W-1:0]  last_reg, last_next;
    logic              none_reg, none_next;
    // stage 1
    logic [KMER_W-1:0]   fwd1_reg;
    logic [2*KMER_W-1:0] span_reg, span_next;
    logic [KMER_W-1:0]   mask1_reg;
    logic [CFG_W-1:0]    last1_reg;
    logic                none1_reg;

    logic [CFG_W-1:0] sh_reg [OUT];
    logic [CFG_W-1:0] sh_next;

    cand_t node_reg [2*LANES-1];

    logic [KMER_W-1:0] value_reg;
    logic [IDX_W-1:0]  index_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kmer_length_reg   <= CFG_W'(31);
            window_length_reg <= CFG_W'(15);
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_KMER_LENGTH:   kmer_length_reg   <= cfg_data;
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stall chain: a stage loads when empty or when the one after it moves
    always_comb
    begin
        adv[OUT] = !vld_reg[OUT] || out_ready;
        for (int s = OUT - 1; s >= 0; s--) begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s <= OUT; s++) begin
                if (adv[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // stage 0: left-justify the k-mer and its reverse complement
    always_comb
    begin
        logic [CFG_W-1:0] k;
        logic [CFG_W-1:0] m;
        logic [6:0]       sh_full;
        k         = (kmer_length_reg > K_MAX) ? K_MAX : kmer_length_reg;
        m         = window_length_reg;
        none_next = (k == '0) || (m == '0) || (m > k);
        last_next = k - m;
        fwd_next  = packed_kmer << (7'd64 - {k, 1'b0});
        rev_next  = kcm_rc32(packed_kmer & ~({KMER_W{1'b1}} << {k, 1'b0}));
        mask_next = ~({KMER_W{1'b1}} >> {m, 1'b0});
        sh_full   = 7'd64 - {m, 1'b0};
        sh_next   = sh_full[CFG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0]) begin
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
            mask_reg  <= mask_next;
            last_reg  <= last_next;
            none_reg  <= none_next;
        end
    end

    // stage 1: line the reverse complement up so lane i sees window k-m-i
    assign span_next = {{KMER_W{1'b0}}, rev_reg} << {last_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv[1]) begin
            fwd1_reg  <= fwd_reg;
            span_reg  <= span_next;
            mask1_reg <= mask_reg;
            last1_reg <= last_reg;
            none1_reg <= none_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0]) begin
            sh_reg[0] <= sh_next;
        end
        for (int s = 1; s < OUT; s++) begin
            if (adv[s]) begin
                sh_reg[s] <= sh_reg[s-1];
            end
        end
    end

    // stage 2: one lane per window, leaves of the min tree
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        if (i < MAX_KMER_BASES) begin : g_real
            cand_t leaf_next;

            kcm_lane #(
                .LANE (i)
            ) u_lane (
                .fwd         (fwd1_reg),
                .rev_span    (span_reg),
                .top_mask    (mask1_reg),
                .last_window (last1_reg),
                .none        (none1_reg),
                .cand        (leaf_next)
            );

            always_ff @(posedge clk)
            begin
                if (adv[2]) begin
                    node_reg[LANES-1+i] <= leaf_next;
                end
            end
        end
        else begin : g_pad
            always_ff @(posedge clk)
            begin
                if (adv[2]) begin
                    node_reg[LANES-1+i] <= '0;
                end
            end
        end
    end

    // min tree, one level per stage; heap order keeps lower windows on the left
    for (genvar n = 0; n < LANES - 1; n++) begin : g_node
        localparam int DEPTH = $clog2(n + 2) - 1;
        localparam int ST    = 2 + LOG - DEPTH;

        always_ff @(posedge clk)
        begin
            if (adv[ST]) begin
                node_reg[n] <= kcm_pick(node_reg[2*n+1], node_reg[2*n+2]);
            end
        end
    end

    // output stage: right-justify, or report no window
    always_ff @(posedge clk)
    begin
        if (adv[OUT]) begin
            if (node_reg[0].vld) begin
                value_reg <= node_reg[0].val >> sh_reg[OUT-1];
                index_reg <= node_reg[0].idx;
            end
            else begin
                value_reg <= NO_WINDOW_VALUE;
                index_reg <= '0;
            end
        end
    end

    assign out_valid       = vld_reg[OUT];
    assign minimizer_value = value_reg;
    assign minimizer_index = index_reg;

endmodule

// ----- sv/kcm_lane.sv -----
// One window lane: cuts a left-justified window and its reverse complement,
// keeps the smaller. Depends on kcm_pkg.
module kcm_lane #(
    parameter int LANE = 0
) (
    input  logic [kcm_pkg::KMER_W-1:0]   fwd,
    input  logic [2*kcm_pkg::KMER_W-1:0] rev_span,
    input  logic [kcm_pkg::KMER_W-1:0]   top_mask,
    input  logic [kcm_pkg::CFG_W-1:0]    last_window,
    input  logic                         none,
    output kcm_pkg::cand_t               cand
);
    import kcm_pkg::*;

    localparam int HI = KMER_W - 1 + 2 * LANE;

    logic [KMER_W-1:0] fwd_win;
    logic [KMER_W-1:0] rev_win;

    // Both windows stay left-justified, so their order is the order of the
    // right-justified values.
    always_comb
    begin
        fwd_win   = (fwd << (2 * LANE)) & top_mask;
        rev_win   = rev_span[HI -: KMER_W] & top_mask;
        cand.vld  = !none && (CFG_W'(LANE) <= last_window);
        cand.val  = (rev_win < fwd_win) ? rev_win : fwd_win;
        cand.idx  = IDX_W'(LANE);
    end

endmodule

// ----- sv/kcm_checker.sv -----
// Port-level checks for kmer_canonical_minimizer, attached by bind.
// Depends on kcm_pkg.
module kcm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [kcm_pkg::KMER_W-1:0] minimizer_value,
    input logic [kcm_pkg::IDX_W-1:0]  minimizer_index
);
    import kcm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(minimizer_value)
            && $stable(minimizer_index))
        else $error("result changed while stalled");

    // an empty output stage never back-pressures the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output stage empty");

    // a real canonical window is never all ones, so that code means no window
    a_no_window_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (minimizer_value == NO_WINDOW_VALUE) |-> minimizer_index == '0)
        else $error("no-window result with nonzero index");

endmodule

bind kmer_canonical_minimizer kcm_checker u_kcm_checker (.*);

// ----- bench/tb_kmer_canonical_minimizer.sv -----
// Self-checking bench for kmer_canonical_minimizer: random and corner k-mers under
// many length settings, with idle/stall phases on both sides. Depends on kcm_pkg.
`timescale 1ns / 100ps

module tb_kmer_canonical_minimizer;
    import kcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES = 16;   // pipeline is 9 deep at 32 bases
    localparam int LONG_HOLD     = 120;

    typedef struct packed {
        logic [KMER_W-1:0] value;
        logic [IDX_W-1:0]  index;
    } minimizer_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [KMER_W-1:0]    packed_kmer = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [KMER_W-1:0]    minimizer_value;
    logic [IDX_W-1:0]     minimizer_index;

    // bench copy of the length registers
    logic [CFG_W-1:0]     kmer_len_reg = 6'd31;
    logic [CFG_W-1:0]     window_len_reg = 6'd15;

    logic [KMER_W-1:0]    kmer_backlog[$];
    minimizer_t           pending_minimizers[$];

    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_requests = 0;
    int                   holds_served = 0;
    int                   hold_left = 0;
    int                   fail_count = 0;

    kmer_canonical_minimizer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .packed_kmer     (packed_kmer),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .minimizer_value (minimizer_value),
        .minimizer_index (minimizer_index)
    );

    always #2 clk = ~clk;

    function automatic minimizer_t min_canonical_window(input logic [CFG_W-1:0] k_reg,
                                                        input logic [CFG_W-1:0] m_reg,
                                                        input logic [KMER_W-1:0] kmer);
        int unsigned       k;
        int unsigned       m;
        int unsigned       shift;
        logic [KMER_W-1:0] seq;
        logic [KMER_W-1:0] wmask;
        logic [KMER_W-1:0] win;
        logic [KMER_W-1:0] rc;
        logic [KMER_W-1:0] canon;
        minimizer_t        res;
        k = 32'(k_reg);
        m = 32'(m_reg);
        if (k > 32)
            k = 32;
        res.value = NO_WINDOW_VALUE;
        res.index = '0;
        if (k != 0 && m != 0 && m <= k) begin
            seq   = (k == 32) ? kmer : kmer & ((64'd1 << (2 * k)) - 64'd1);
            wmask = (m == 32) ? '1 : (64'd1 << (2 * m)) - 64'd1;
            for (int unsigned i = 0; i <= k - m; i++) begin
                shift = 2 * (k - m - i);
                win = (seq >> shift) & wmask;
                rc = '0;
                for (int unsigned b = 0; b < m; b++) begin
                    rc = {rc[KMER_W-3:0], 2'd3 - win[2*b +: 2]};
                end
                canon = (rc < win) ? rc : win;
                // later window wins a tie
                if (canon <= res.value) begin
                    res.value = canon;
                    res.index = i[IDX_W-1:0];
                end
            end
        end
        return res;
    endfunction

    // append one k-mer to the driver's backlog
    function automatic void queue_kmer(input logic [KMER_W-1:0] v);
        kmer_backlog = {kmer_backlog, v};
    endfunction

    // Mix of plain random, periodic, reverse-complement palindromes and
    // near-homopolymers so ties and canonical flips come up often.
    function automatic logic [KMER_W-1:0] random_kmer();
        logic [KMER_W-1:0] v;
        logic [7:0]        motif;
        logic [1:0]        base;
        int unsigned       period;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            4, 5: begin
                period = $urandom_range(1, 4);
                motif = 8'($urandom);
                for (int unsigned b = 0; b < 32; b++)
                    v[2*b +: 2] = motif[2*(b % period) +: 2];
            end
            6: begin
                for (int unsigned b = 0; b < 16; b++)
                    v[2*b +: 2] = 2'd3 - v[2*(31-b) +: 2];
            end
            7: begin
                base = 2'($urandom);
                for (int unsigned b = 0; b < 32; b++)
                    v[2*b +: 2] = base;
                v[2*$urandom_range(31) +: 2] = 2'($urandom);
                v[2*$urandom_range(31) +: 2] = 2'($urandom);
            end
            default: ;
        endcase
        return v;
    endfunction

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                pending_minimizers = {pending_minimizers,
                    min_canonical_window(kmer_len_reg, window_len_reg, packed_kmer)};
            if (!in_valid || in_ready) begin
                if (kmer_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    packed_kmer <= kmer_backlog.pop_front();
                    in_valid    <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk) begin
        minimizer_t exp_item;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_minimizers.size() == 0) begin
                    $error("unexpected item: value %h index %0d",
                           minimizer_value, minimizer_index);
                    fail_count++;
                end
                else begin
                    exp_item = pending_minimizers.pop_front();
                    if (minimizer_value !== exp_item.value) begin
                        $error("minimizer_value: expected %h, got %h",
                               exp_item.value, minimizer_value);
                        fail_count++;
                    end
                    if (minimizer_index !== exp_item.index) begin
                        $error("minimizer_index: expected %0d, got %0d",
                               exp_item.index, minimizer_index);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (holds_served != hold_requests) begin
                holds_served <= holds_served + 1;
                hold_left    <= LONG_HOLD;
                out_ready    <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_KMER_LENGTH)
            kmer_len_reg = data;
        else if (idx == REG_WINDOW_LENGTH)
            window_len_reg = data;
    endtask

    task automatic apply_lengths(input logic [CFG_W-1:0] k_data,
                                 input logic [CFG_W-1:0] m_data,
                                 input bit spare_writes);
        if (spare_writes)
            write_reg(REG_SPARE_3, CFG_W'($urandom));
        write_reg(REG_KMER_LENGTH, k_data);
        write_reg(REG_WINDOW_LENGTH, m_data);
        if (spare_writes)
            write_reg(REG_SPARE_2, CFG_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every item is through, then let the pipeline go quiet
    task automatic drain_and_settle();
        while (kmer_backlog.size() != 0 || in_valid || pending_minimizers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_corners();
        queue_kmer('0);
        queue_kmer('1);
        queue_kmer(64'h1B1B_1B1B_1B1B_1B1B);   // ACGT repeat
        queue_kmer(64'hE4E4_E4E4_E4E4_E4E4);   // TGCA repeat
        drain_and_settle();
    endtask

    task automatic pick_random_lengths();
        logic [CFG_W-1:0] k_data;
        logic [CFG_W-1:0] m_data;
        int unsigned      k_eff;
        case ($urandom_range(19))
            0:       k_data = 6'd0;
            1:       k_data = CFG_W'($urandom_range(33, 63));
            2:       k_data = 6'd32;
            default: k_data = CFG_W'($urandom_range(1, 32));
        endcase
        k_eff = (k_data > 6'd32) ? 32 : 32'(k_data);
        if (k_eff == 0)
            k_eff = $urandom_range(1, 32);
        case ($urandom_range(9))
            0:       m_data = 6'd0;
            1:       m_data = CFG_W'($urandom_range(33, 63));
            2:       m_data = (k_eff < 32) ? CFG_W'(k_eff + 1) : 6'd33;
            3:       m_data = CFG_W'(k_eff);
            default: m_data = CFG_W'($urandom_range(1, k_eff));
        endcase
        apply_lengths(k_data, m_data, $urandom_range(3) == 0);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // corners under reset lengths, then the extremes
        run_corners();
        apply_lengths(6'd32, 6'd32, 1'b0);
        run_corners();
        apply_lengths(6'd32, 6'd1, 1'b1);
        run_corners();
        apply_lengths(6'd1, 6'd1, 1'b0);
        queue_kmer(64'hFFFF_FFFF_FFFF_FFFC);
        queue_kmer(64'h0000_0000_0000_0003);
        drain_and_settle();
        // window longer than k-mer, zero lengths, saturated k-mer length
        apply_lengths(6'd7, 6'd8, 1'b0);
        queue_kmer(random_kmer());
        drain_and_settle();
        apply_lengths(6'd0, 6'd5, 1'b0);
        queue_kmer(random_kmer());
        drain_and_settle();
        apply_lengths(6'd12, 6'd0, 1'b0);
        queue_kmer(random_kmer());
        drain_and_settle();
        apply_lengths(6'd63, 6'd32, 1'b1);
        run_corners();
        apply_lengths(6'd45, 6'd33, 1'b0);
        queue_kmer(random_kmer());
        drain_and_settle();

        for (int batch = 0; batch < 19; batch++) begin
            pick_random_lengths();
            case (batch % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int n = 0; n < 100; n++)
                queue_kmer(random_kmer());
            // long receiver hold while the sender keeps offering
            if (batch == 4 || batch == 12)
                hold_requests++;
            drain_and_settle();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (pending_minimizers.size() != 0) begin
            $error("%0d expected items never arrived", pending_minimizers.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/kcm_pkg.sv
sv/kcm_lane.sv
sv/kmer_canonical_minimizer.sv
sv/kcm_checker.sv
bench/tb_kmer_canonical_minimizer.sv
